// ----- design/wstq_pkg.sv -----
package wstq_pkg;

    localparam int TASK_FIELD_W   = 32;
    localparam int CNT_FIELD_W    = 7;
    localparam int ADDR_FIELD_W   = 6;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TASK_WIDTH_DEF  = 32;

    localparam int STEAL_SMALL      = 8;
    localparam int STEAL_LARGE      = 64;
    localparam int DIV3_MUL         = 43;
    localparam int DIV3_SHIFT       = 7;
    localparam int TWO_FIFTHS_MUL   = 205;
    localparam int TWO_FIFTHS_SHIFT = 9;

    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_PUSH       = 2'd0,
        ACT_STEAL      = 2'd1,
        ACT_DRAIN_SOME = 2'd2,
        ACT_DRAIN_ALL  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_TAKE = 2'd2
    } cmd_op_t;

    typedef struct packed {
        action_t                   action;
        logic [TASK_FIELD_W-1:0]   task_handle;
        logic [CNT_FIELD_W-1:0]    take_limit;
        logic [CNT_FIELD_W-1:0]    keep_floor;
    } req_t;

    typedef struct packed {
        logic [TASK_FIELD_W-1:0]   out_task;
        logic                      task_valid;
        logic                      last;
        status_t                   status;
        logic [CNT_FIELD_W-1:0]    remaining;
    } rsp_t;

    typedef struct packed {
        cmd_op_t                   op;
        logic                      from_tail;
        logic [ADDR_FIELD_W-1:0]   addr;
        logic [CNT_FIELD_W-1:0]    count;
        status_t                   status;
        logic [CNT_FIELD_W-1:0]    remaining;
        logic [TASK_FIELD_W-1:0]   handle;
    } cmd_t;

    typedef struct packed {
        logic                      task_valid;
        logic                      last;
        status_t                   status;
        logic [CNT_FIELD_W-1:0]    remaining;
    } rsp_meta_t;

endpackage

// ----- design/wstq_ram.sv -----
module wstq_ram #(
    parameter int WIDTH = wstq_pkg::TASK_WIDTH_DEF,
    parameter int DEPTH = wstq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/wstq_front.sv -----
module wstq_front #(
    parameter int QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  wstq_pkg::req_t req,
    input  logic           q_full,
    output logic           cmd_push,
    output wstq_pkg::cmd_t cmd
);
    import wstq_pkg::*;

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = AW + 2;
    localparam int PROD_W = CNT_FIELD_W + 8;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [AW-1:0]          head_reg, head_next;
    logic                   accept;

    logic [CNT_FIELD_W-1:0] total7;
    logic [CNT_FIELD_W-1:0] target7;
    logic [CNT_FIELD_W-1:0] room7;
    logic [CNT_FIELD_W-1:0] steal7;
    logic [PROD_W-1:0]      prod3;
    logic [PROD_W-1:0]      prod5;
    logic [CNT_W-1:0]       take_n;
    logic                   from_tail;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return AW'(sum);
    endfunction

    assign accept    = req_valid && !q_full;
    assign req_stall = q_full;
    assign cmd_push  = accept;

    // steal batch size
    always_comb
    begin
        total7 = CNT_FIELD_W'(count_reg);
        prod3  = PROD_W'(total7) * PROD_W'(DIV3_MUL);
        prod5  = PROD_W'(total7) * PROD_W'(TWO_FIFTHS_MUL);
        room7  = total7 - req.keep_floor;
        if (total7 >= CNT_FIELD_W'(STEAL_LARGE))
        begin
            target7 = CNT_FIELD_W'(prod5 >> TWO_FIFTHS_SHIFT);
        end
        else if (total7 >= CNT_FIELD_W'(STEAL_SMALL))
        begin
            target7 = CNT_FIELD_W'(prod3 >> DIV3_SHIFT);
        end
        else
        begin
            target7 = CNT_FIELD_W'(1);
        end
        if (target7 == '0)
        begin
            target7 = CNT_FIELD_W'(1);
        end
        steal7 = target7;
        if (room7 < steal7)
        begin
            steal7 = room7;
        end
        if (req.take_limit < steal7)
        begin
            steal7 = req.take_limit;
        end
        if (req.take_limit == '0 || total7 <= req.keep_floor)
        begin
            steal7 = '0;
        end
    end

    // classify
    always_comb
    begin
        cmd           = '0;
        cmd.handle    = req.task_handle;
        cmd.status    = ST_OK;
        cmd.op        = CMD_NONE;
        cmd.remaining = CNT_FIELD_W'(count_reg);
        count_next    = count_reg;
        head_next     = head_reg;
        take_n        = '0;
        from_tail     = 1'b0;

        case (req.action)
            ACT_STEAL:
            begin
                take_n    = CNT_W'(steal7);
                from_tail = 1'b1;
            end
            ACT_DRAIN_SOME:
            begin
                take_n = (req.take_limit < CNT_FIELD_W'(count_reg))
                         ? CNT_W'(req.take_limit) : count_reg;
            end
            ACT_DRAIN_ALL:
            begin
                take_n = count_reg;
            end
            default:
            begin
                take_n = '0;
            end
        endcase

        if (req.action == ACT_PUSH)
        begin
            if (count_reg >= CNT_W'(QUEUE_DEPTH))
            begin
                cmd.status = ST_FULL;
            end
            else
            begin
                cmd.op        = CMD_PUSH;
                cmd.addr      = ADDR_FIELD_W'(ring_add(head_reg, count_reg));
                cmd.remaining = CNT_FIELD_W'(count_reg + CNT_W'(1));
                count_next    = count_reg + CNT_W'(1);
            end
        end
        else if (take_n == '0)
        begin
            cmd.status = ST_EMPTY;
        end
        else
        begin
            cmd.op        = CMD_TAKE;
            cmd.from_tail = from_tail;
            cmd.count     = CNT_FIELD_W'(take_n);
            cmd.remaining = CNT_FIELD_W'(count_reg - take_n);
            count_next    = count_reg - take_n;
            if (from_tail)
            begin
                cmd.addr = ADDR_FIELD_W'(ring_add(head_reg, count_reg - CNT_W'(1)));
            end
            else
            begin
                cmd.addr  = ADDR_FIELD_W'(head_reg);
                head_next = ring_add(head_reg, take_n);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

endmodule

// ----- design/wstq_cmd_fifo.sv -----
module wstq_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wstq_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output wstq_pkg::cmd_t head
);
    import wstq_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             slot_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full  = (fill_reg == CNT_W'(CMDQ_DEPTH));
    assign valid = (fill_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- design/wstq_back.sv -----
module wstq_back #(
    parameter int QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_WIDTH  = wstq_pkg::TASK_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  wstq_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output wstq_pkg::rsp_t rsp
);
    import wstq_pkg::*;

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_W = (TASK_WIDTH < TASK_FIELD_W) ? TASK_WIDTH : TASK_FIELD_W;

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic               p1_valid_reg, p1_valid_next;
    rsp_meta_t          p1_meta_reg, p1_meta_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg;

    logic               out_load;
    logic               p1_free;
    logic               issue;
    logic               step_last;
    logic [AW-1:0]      addr;
    logic               ram_we;
    logic               ram_re;
    logic [STORE_W-1:0] ram_rdata;

    assign out_load  = p1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign p1_free   = !p1_valid_reg || out_load;
    assign issue     = cmd_valid && p1_free;
    assign addr      = (idx_reg == '0) ? cmd.addr[AW-1:0] : ptr_reg;
    assign step_last = (cmd.op != CMD_TAKE)
                       || (CNT_W'(idx_reg + CNT_W'(1)) == cmd.count[CNT_W-1:0]);
    assign cmd_pop   = issue && step_last;
    assign ram_we    = issue && (cmd.op == CMD_PUSH);
    assign ram_re    = issue && (cmd.op == CMD_TAKE);

    wstq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (cmd.handle[STORE_W-1:0]),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        p1_valid_next = p1_valid_reg;
        p1_meta_next  = p1_meta_reg;
        if (out_load)
        begin
            p1_valid_next = 1'b0;
        end
        if (issue)
        begin
            idx_next                = step_last ? '0 : CNT_W'(idx_reg + CNT_W'(1));
            p1_valid_next           = 1'b1;
            p1_meta_next.task_valid = (cmd.op == CMD_TAKE);
            p1_meta_next.last       = step_last;
            p1_meta_next.status     = cmd.status;
            p1_meta_next.remaining  = cmd.remaining;
            if (cmd.from_tail)
            begin
                ptr_next = (addr == '0) ? AW'(QUEUE_DEPTH - 1) : AW'(addr - 1'b1);
            end
            else
            begin
                ptr_next = (addr == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(addr + 1'b1);
            end
        end
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.out_task   <= p1_meta_reg.task_valid ? TASK_FIELD_W'(ram_rdata) : '0;
            out_reg.task_valid <= p1_meta_reg.task_valid;
            out_reg.last       <= p1_meta_reg.last;
            out_reg.status     <= p1_meta_reg.status;
            out_reg.remaining  <= p1_meta_reg.remaining;
        end
        p1_meta_reg <= p1_meta_next;
        ptr_reg     <= ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- design/work_steal_task_queue_unit.sv -----
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  wstq_pkg::req_t
// rsp       out        rsp_valid / rsp_stall  wstq_pkg::rsp_t
//
// Pushes follow each other one per cycle while req_stall is low. A steal or
// drain of n tasks gives n transactions, one per cycle from the single read
// port of the task store while rsp_stall is low; nothing taken gives one
// transaction. Each passes the command queue, the store read and metadata
// registers, then the output register. Reset clears counts and the head and
// queue pointers; store contents stay unknown, no clearing pass. rsp_stall holds
// the output register; the two-entry command queue fills and raises req_stall.
module work_steal_task_queue_unit #(
    parameter int QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_WIDTH  = wstq_pkg::TASK_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  wstq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output wstq_pkg::rsp_t rsp
);
    import wstq_pkg::*;

    cmd_t front_cmd;
    cmd_t q_head;
    logic front_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    wstq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    wstq_cmd_fifo u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    wstq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_WIDTH  (TASK_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- verif/work_steal_task_queue_unit_test.sv -----
module work_steal_task_queue_unit_test;
    import wstq_pkg::*;

    class deque_scoreboard;
        logic [31:0] slot [64];
        logic [5:0]  head_pos;
        int unsigned depth_used;
        rsp_t        awaited [$];
        int unsigned mismatches;
        int unsigned reqs_in;
        int unsigned rsps_out;
        int unsigned tasks_out;
        int unsigned full_drops;
        int unsigned empty_takes;

        function new();
            head_pos    = '0;
            depth_used  = 0;
            mismatches  = 0;
            reqs_in     = 0;
            rsps_out    = 0;
            tasks_out   = 0;
            full_drops  = 0;
            empty_takes = 0;
        endfunction

        function void queue_rsp(logic [31:0] handle, logic valid, logic fin, status_t st);
            rsp_t r;
            r.out_task   = handle;
            r.task_valid = valid;
            r.last       = fin;
            r.status     = st;
            r.remaining  = depth_used[6:0];
            awaited.insert(awaited.size(), r);
        endfunction

        function void note_request(req_t r);
            int unsigned total;
            int unsigned take;
            int unsigned goal;
            int unsigned room;
            int unsigned i;
            logic [5:0]  pos;
            total = depth_used;
            take  = 0;
            reqs_in++;
            case (r.action)
                ACT_PUSH:
                begin
                    if (total >= 64)
                    begin
                        queue_rsp('0, 1'b0, 1'b1, ST_FULL);
                        full_drops++;
                    end
                    else
                    begin
                        pos = head_pos + 6'(total);
                        slot[pos] = r.task_handle;
                        depth_used = total + 1;
                        queue_rsp('0, 1'b0, 1'b1, ST_OK);
                    end
                    return;
                end
                ACT_STEAL:
                begin
                    if (r.take_limit != 0 && total > r.keep_floor)
                    begin
                        goal = 1;
                        if (total >= 64)
                            goal = (total * 2) / 5;
                        else if (total >= 8)
                            goal = total / 3;
                        if (goal == 0)
                            goal = 1;
                        room = total - r.keep_floor;
                        take = goal;
                        if (room < take)
                            take = room;
                        if (r.take_limit < take)
                            take = r.take_limit;
                    end
                end
                ACT_DRAIN_SOME:
                    take = (r.take_limit < total) ? r.take_limit : total;
                default:
                    take = total;
            endcase
            if (take == 0)
            begin
                queue_rsp('0, 1'b0, 1'b1, ST_EMPTY);
                empty_takes++;
                return;
            end
            depth_used = total - take;
            for (i = 0; i < take; i++)
            begin
                if (r.action == ACT_STEAL)
                    pos = head_pos + 6'(total - 1 - i);
                else
                    pos = head_pos + 6'(i);
                queue_rsp(slot[pos], 1'b1, (i + 1 == take), ST_OK);
                tasks_out++;
            end
            if (r.action != ACT_STEAL)
                head_pos = head_pos + 6'(take);
        endfunction

        function void flag_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            rsps_out++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                $display("%0t: response with none awaited, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            if (got.out_task !== want.out_task)
                flag_field("out_task", want.out_task, got.out_task);
            if (got.task_valid !== want.task_valid)
                flag_field("task_valid", 32'(want.task_valid), 32'(got.task_valid));
            if (got.last !== want.last)
                flag_field("last", 32'(want.last), 32'(got.last));
            if (got.status !== want.status)
                flag_field("status", 32'(want.status), 32'(got.status));
            if (got.remaining !== want.remaining)
                flag_field("remaining", 32'(want.remaining), 32'(got.remaining));
        endfunction
    endclass

    localparam int CLK_PERIOD      = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TIMEOUT_CYCLES  = 400000;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    bit          idle_on;
    bit          hold_off_pending;
    int unsigned hold_left;

    deque_scoreboard sb;

    work_steal_task_queue_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    initial
    begin
        rsp_stall <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= idle_on && ($urandom_range(0, 99) < 37);
        end
    end

    function automatic req_t make_req(action_t a, logic [31:0] handle,
                                      int unsigned mc, int unsigned mr);
        req_t r;
        r.action      = a;
        r.task_handle = handle;
        r.take_limit  = 7'(mc);
        r.keep_floor  = 7'(mr);
        return r;
    endfunction

    function automatic int unsigned pick_count();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return 64;
        if (sel < 5)
            return $urandom_range(1, 4);
        return $urandom_range(0, 64);
    endfunction

    function automatic int unsigned pick_reserve();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 64;
        if (sel < 6)
            return $urandom_range(0, 4);
        return $urandom_range(0, 64);
    endfunction

    task automatic offer(input req_t item);
        while (idle_on && $urandom_range(0, 99) < 37)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_mix(input int unsigned n);
        int unsigned k;
        int unsigned pick;
        int unsigned burst;
        int unsigned j;
        action_t     a;
        k = 0;
        while (k < n)
        begin
            pick = $urandom_range(0, 99);
            if ((sb.depth_used < 6) ? (pick < 70) : (pick < 45))
                a = ACT_PUSH;
            else if (pick < 75)
                a = ACT_STEAL;
            else if (pick < 95)
                a = ACT_DRAIN_SOME;
            else
                a = ACT_DRAIN_ALL;
            if (a == ACT_PUSH && $urandom_range(0, 14) == 0)
            begin
                burst = $urandom_range(10, 40);
                for (j = 0; j < burst; j++)
                    offer(make_req(ACT_PUSH, $urandom(), pick_count(), pick_reserve()));
                k += burst;
            end
            else
            begin
                offer(make_req(a, $urandom(), pick_count(), pick_reserve()));
                k++;
            end
        end
    endtask

    initial
    begin
        int unsigned k;
        sb = new();
        idle_on = 1'b1;
        hold_off_pending = 1'b0;
        rst_n = 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        offer(make_req(ACT_STEAL, 32'h0, 64, 0));
        offer(make_req(ACT_DRAIN_SOME, 32'h0, 64, 0));
        offer(make_req(ACT_DRAIN_ALL, 32'h0, 0, 0));
        offer(make_req(ACT_PUSH, 32'h0000_0000, 0, 0));
        offer(make_req(ACT_PUSH, 32'hFFFF_FFFF, 64, 64));
        for (k = 0; k < 6; k++)
            offer(make_req(ACT_PUSH, $urandom(), 63, 63));
        offer(make_req(ACT_STEAL, 32'h0, 0, 0));
        offer(make_req(ACT_STEAL, 32'h0, 64, 64));
        offer(make_req(ACT_STEAL, 32'h0, 64, 0));
        offer(make_req(ACT_STEAL, 32'h0, 64, 5));
        offer(make_req(ACT_DRAIN_SOME, 32'h0, 0, 0));
        offer(make_req(ACT_DRAIN_SOME, 32'h0, 2, 0));
        offer(make_req(ACT_STEAL, 32'h0, 1, 2));
        offer(make_req(ACT_DRAIN_SOME, 32'h0, 64, 0));
        offer(make_req(ACT_DRAIN_ALL, 32'h0, 64, 64));
        for (k = 0; k < 3; k++)
            offer(make_req(ACT_PUSH, $urandom(), 0, 0));
        offer(make_req(ACT_DRAIN_ALL, 32'h0, 0, 0));

        random_mix(100);
        idle_on = 1'b0;
        random_mix(60);
        idle_on = 1'b1;

        // hold the receiver off so the queue fills and pushes back
        offer(make_req(ACT_DRAIN_ALL, 32'h0, 0, 0));
        hold_off_pending = 1'b1;
        for (k = 0; k < 70; k++)
            offer(make_req(ACT_PUSH, $urandom(), pick_count(), pick_reserve()));
        offer(make_req(ACT_STEAL, 32'h0, 64, 0));
        offer(make_req(ACT_STEAL, 32'h0, 3, 0));
        offer(make_req(ACT_DRAIN_SOME, 32'h0, 64, 0));

        random_mix(90);
        req_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d requests and %0d responses, %0d tasks handed out,",
                 sb.reqs_in, sb.rsps_out, sb.tasks_out);
        $display("%0d pushes dropped on a full queue, %0d operations that took nothing.",
                 sb.full_drops, sb.empty_takes);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- work_steal_task_queue_unit.f -----
design/wstq_pkg.sv
design/wstq_ram.sv
design/wstq_front.sv
design/wstq_cmd_fifo.sv
design/wstq_back.sv
design/work_steal_task_queue_unit.sv
verif/work_steal_task_queue_unit_test.sv
